// ===== rtl/cprf_pkg.sv =====
// Package for the contiguous page run finder.
// Holds the request and result transaction types, request and status codes
// and the sequencer state type. It depends on nothing.
`timescale 1ns / 1ps

package cprf_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_SET  = 2'd1,
        REQ_DOWN = 2'd2,
        REQ_UP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD      = 2'd1,
        STAT_CROSS    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    localparam logic [1:0] PG_FREE     = 2'd0;
    localparam logic [1:0] PG_RESERVED = 2'd1;

    localparam logic [35:0] LIMIT_RESET = 36'd256;
    localparam int          FRAME_SHIFT = 12;
    localparam int          AW          = 52;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [35:0] page_frame;
        logic [12:0] run_len;
        logic [5:0]  align_exp;
        logic [1:0]  new_state;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [36:0] result_frame;
        logic [12:0] free_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SET_FIND,
        S_SET_RD,
        S_SET_WR,
        S_DN_RNG,
        S_DN_POS,
        S_DN_CHK,
        S_DN_RUN,
        S_UP_RNG,
        S_UP_POS,
        S_UP_CHK,
        S_UP_RUN,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/contiguous_page_run_finder_top.sv =====
// Top level of the contiguous page run finder: sequencer, page state memory,
// range table and output register in one module.
// Depends on cprf_pkg.
`timescale 1ns / 1ps

// The block keeps a two-bit state per page over up to INTERVALS loaded ranges
// and answers load, set, top-down probe and bottom-up probe requests.
// Requests enter on i_in_data with i_in_valid; o_in_stall is high while a
// request is in work, so one transaction is handled at a time.
// Each request produces one result transaction on o_out_data with o_out_valid.
// A load writes the pages of the new range in turn, and a set first searches
// the ranges in order and then reads and writes each page of the run. A probe
// checks scan positions, each further page of a candidate run and each range
// visited in turn; its length depends on the map contents.
// The low reserved limit is written on the cfg channel, which is always ready.
// If the receiver stalls, the finished result stays in the output register and
// the sequencer waits in its final step until the register frees.
// Synchronous reset clears the range count, free count, cursors and the
// output valid and sets the limit to 256; page memory is not cleared.
module contiguous_page_run_finder_top #(
    parameter int PAGES     = 4096,
    parameter int INTERVALS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cprf_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cprf_pkg::t_out   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [35:0]      i_cfg_data
);

    localparam int PW  = $clog2(PAGES + 1);
    localparam int IW  = $clog2(PAGES);
    localparam int RW  = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
    localparam int CTW = $clog2(INTERVALS + 1);
    localparam int AW  = cprf_pkg::AW;

    logic [1:0]    r_mem [PAGES];
    logic [1:0]    r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [IW-1:0] mem_ra;
    logic [1:0]    mem_wd;

    logic [35:0]   r_rbase  [INTERVALS];
    logic [PW-1:0] r_rpages [INTERVALS];
    logic [IW-1:0] r_rfirst [INTERVALS];
    logic          rng_we;
    logic [RW-1:0] rng_wi;

    cprf_pkg::t_state  r_state, n_state;
    cprf_pkg::t_status r_stat, n_stat;
    logic [36:0]   r_res, n_res;
    logic [CTW-1:0] r_rc, n_rc;
    logic [CTW-1:0] r_ri, n_ri;
    logic [PW-1:0] r_used, n_used;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_k, n_k;
    logic [12:0]   r_j, n_j;
    logic [36:0]   r_top, n_top;
    logic [36:0]   r_bot, n_bot;
    logic [35:0]   r_limit;
    logic [35:0]   r_base0, n_base0;
    logic [35:0]   r_frame, n_frame;
    logic [12:0]   r_cnt, n_cnt;
    logic [AW-1:0] r_mask, n_mask;
    logic [1:0]    r_st, n_st;
    logic          r_out_valid, n_out_valid;
    cprf_pkg::t_out r_out, n_out;

    logic [RW-1:0] ri_sel;
    logic [35:0]   rb;
    logic [PW-1:0] rp;
    logic [IW-1:0] rf;
    logic [AW-1:0] top52;
    logic [AW-1:0] al52;
    logic [AW-1:0] addr52;
    logic [AW-1:0] nk52;
    logic [36:0]   end37;
    logic [36:0]   load_frame;
    logic          accept;

    assign o_in_stall  = (r_state != cprf_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_state == cprf_pkg::S_DN_RNG || r_state == cprf_pkg::S_DN_POS ||
            r_state == cprf_pkg::S_DN_CHK || r_state == cprf_pkg::S_DN_RUN) begin
            ri_sel = RW'(r_ri - 1'b1);
        end else begin
            ri_sel = RW'(r_ri);
        end
    end

    assign rb         = r_rbase[ri_sel];
    assign rp         = r_rpages[ri_sel];
    assign rf         = r_rfirst[ri_sel];
    assign end37      = 37'(rb) + 37'(rp);
    assign top52      = AW'(rb) + AW'(r_k) + AW'(1);
    assign al52       = top52 & ~r_mask;
    assign addr52     = AW'(rb) + AW'(r_k);
    assign nk52       = ((addr52 + r_mask) & ~r_mask) - AW'(rb);
    assign load_frame = 37'(r_frame) + 37'(r_k);

    always_comb begin
        n_state     = r_state;
        n_stat      = r_stat;
        n_res       = r_res;
        n_rc        = r_rc;
        n_ri        = r_ri;
        n_used      = r_used;
        n_free      = r_free;
        n_k         = r_k;
        n_j         = r_j;
        n_top       = r_top;
        n_bot       = r_bot;
        n_base0     = r_base0;
        n_frame     = r_frame;
        n_cnt       = r_cnt;
        n_mask      = r_mask;
        n_st        = r_st;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = IW'(32'(r_used) + 32'(r_k));
        mem_wd      = cprf_pkg::PG_FREE;
        mem_ra      = IW'(32'(rf) + 32'(r_k));
        rng_we      = 1'b0;
        rng_wi      = RW'(r_rc);

        unique case (r_state)
            cprf_pkg::S_IDLE: begin
                if (accept) begin
                    n_frame = i_in_data.page_frame;
                    n_cnt   = i_in_data.run_len;
                    n_st    = i_in_data.new_state;
                    n_res   = '0;
                    n_k     = '0;
                    n_j     = '0;
                    if (i_in_data.align_exp < 6'(cprf_pkg::FRAME_SHIFT)) begin
                        n_mask = '0;
                    end else begin
                        n_mask = (AW'(1) << (i_in_data.align_exp -
                                 6'(cprf_pkg::FRAME_SHIFT))) - AW'(1);
                    end
                    unique case (cprf_pkg::t_req'(i_in_data.req_type))
                        cprf_pkg::REQ_LOAD: begin
                            if (i_in_data.run_len == '0 ||
                                32'(r_rc) >= 32'(INTERVALS) ||
                                32'(i_in_data.run_len) >
                                32'(PAGES) - 32'(r_used)) begin
                                n_stat  = cprf_pkg::STAT_BAD;
                                n_state = cprf_pkg::S_EMIT;
                            end else begin
                                rng_we = 1'b1;
                                if (r_rc == '0) begin
                                    n_base0 = i_in_data.page_frame;
                                end
                                n_rc    = r_rc + 1'b1;
                                n_state = cprf_pkg::S_LOAD;
                            end
                        end
                        cprf_pkg::REQ_SET: begin
                            if (i_in_data.run_len == '0) begin
                                n_stat  = cprf_pkg::STAT_BAD;
                                n_state = cprf_pkg::S_EMIT;
                            end else begin
                                n_ri    = '0;
                                n_state = cprf_pkg::S_SET_FIND;
                            end
                        end
                        cprf_pkg::REQ_DOWN: begin
                            if (i_in_data.run_len == '0) begin
                                n_stat  = cprf_pkg::STAT_BAD;
                                n_state = cprf_pkg::S_EMIT;
                            end else begin
                                n_ri    = r_rc;
                                n_state = cprf_pkg::S_DN_RNG;
                            end
                        end
                        cprf_pkg::REQ_UP: begin
                            if (i_in_data.run_len == '0) begin
                                n_stat  = cprf_pkg::STAT_BAD;
                                n_state = cprf_pkg::S_EMIT;
                            end else begin
                                n_ri    = '0;
                                n_state = cprf_pkg::S_UP_RNG;
                            end
                        end
                    endcase
                end
            end

            cprf_pkg::S_LOAD: begin
                mem_we = 1'b1;
                if (load_frame < 37'(r_limit)) begin
                    mem_wd = cprf_pkg::PG_RESERVED;
                end else begin
                    mem_wd = cprf_pkg::PG_FREE;
                    n_free = PW'(r_free + 1'b1);
                end
                n_k = PW'(r_k + 1'b1);
                if (32'(r_k) + 1 == 32'(r_cnt)) begin
                    n_used  = PW'(32'(r_used) + 32'(r_cnt));
                    n_top   = 37'(r_frame) + 37'(r_cnt);
                    n_bot   = (r_base0 < r_limit) ? 37'(r_limit) : 37'(r_base0);
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end
            end

            cprf_pkg::S_SET_FIND: begin
                if (r_ri == r_rc) begin
                    n_stat  = cprf_pkg::STAT_CROSS;
                    n_state = cprf_pkg::S_EMIT;
                end else if (r_frame >= rb && 37'(r_frame) < end37) begin
                    if (37'(r_frame) + 37'(r_cnt) > end37) begin
                        n_stat  = cprf_pkg::STAT_CROSS;
                        n_state = cprf_pkg::S_EMIT;
                    end else begin
                        n_k     = PW'(r_frame - rb);
                        n_j     = '0;
                        n_state = cprf_pkg::S_SET_RD;
                    end
                end else begin
                    n_ri = r_ri + 1'b1;
                end
            end

            cprf_pkg::S_SET_RD: begin
                n_state = cprf_pkg::S_SET_WR;
            end

            cprf_pkg::S_SET_WR: begin
                mem_we = 1'b1;
                mem_wa = IW'(32'(rf) + 32'(r_k));
                mem_wd = r_st;
                if (r_rdata == cprf_pkg::PG_FREE && r_st != cprf_pkg::PG_FREE) begin
                    n_free = PW'(r_free - 1'b1);
                end else if (r_rdata != cprf_pkg::PG_FREE &&
                             r_st == cprf_pkg::PG_FREE) begin
                    n_free = PW'(r_free + 1'b1);
                end
                n_k = PW'(r_k + 1'b1);
                n_j = r_j + 1'b1;
                if (r_j + 13'd1 == r_cnt) begin
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end else begin
                    n_state = cprf_pkg::S_SET_RD;
                end
            end

            cprf_pkg::S_DN_RNG: begin
                if (r_ri == '0) begin
                    n_stat  = cprf_pkg::STAT_NOTFOUND;
                    n_res   = '0;
                    n_state = cprf_pkg::S_EMIT;
                end else if (37'(rb) >= r_top) begin
                    n_ri = r_ri - 1'b1;
                end else begin
                    n_k     = PW'(rp - 1'b1);
                    n_state = cprf_pkg::S_DN_POS;
                end
            end

            cprf_pkg::S_DN_POS: begin
                n_state = cprf_pkg::S_DN_CHK;
            end

            cprf_pkg::S_DN_CHK: begin
                if (r_rdata != cprf_pkg::PG_FREE) begin
                    if (r_k == '0) begin
                        n_ri    = r_ri - 1'b1;
                        n_state = cprf_pkg::S_DN_RNG;
                    end else begin
                        n_k     = PW'(r_k - 1'b1);
                        n_state = cprf_pkg::S_DN_POS;
                    end
                end else if ((top52 & r_mask) != '0) begin
                    if (al52 <= AW'(rb)) begin
                        n_ri    = r_ri - 1'b1;
                        n_state = cprf_pkg::S_DN_RNG;
                    end else begin
                        n_k     = PW'(al52 - AW'(rb) - AW'(1));
                        n_state = cprf_pkg::S_DN_POS;
                    end
                end else if (32'(r_k) + 1 < 32'(r_cnt)) begin
                    n_ri    = r_ri - 1'b1;
                    n_state = cprf_pkg::S_DN_RNG;
                end else if (r_cnt == 13'd1) begin
                    n_res   = 37'(top52);
                    n_top   = 37'(top52);
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end else begin
                    n_j     = 13'd1;
                    mem_ra  = IW'(32'(rf) + 32'(r_k) - 1);
                    n_state = cprf_pkg::S_DN_RUN;
                end
            end

            cprf_pkg::S_DN_RUN: begin
                if (r_rdata != cprf_pkg::PG_FREE) begin
                    if (32'(r_k) == 32'(r_j)) begin
                        n_ri    = r_ri - 1'b1;
                        n_state = cprf_pkg::S_DN_RNG;
                    end else begin
                        n_k     = PW'(32'(r_k) - 32'(r_j) - 1);
                        n_state = cprf_pkg::S_DN_POS;
                    end
                end else if (r_j + 13'd1 == r_cnt) begin
                    n_res   = 37'(top52);
                    n_top   = 37'(top52);
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end else begin
                    n_j    = r_j + 1'b1;
                    mem_ra = IW'(32'(rf) + 32'(r_k) - 32'(r_j) - 1);
                end
            end

            cprf_pkg::S_UP_RNG: begin
                if (r_ri == r_rc) begin
                    n_stat  = cprf_pkg::STAT_NOTFOUND;
                    n_res   = '0;
                    n_state = cprf_pkg::S_EMIT;
                end else if (end37 <= r_bot) begin
                    n_ri = r_ri + 1'b1;
                end else begin
                    n_k     = '0;
                    n_state = cprf_pkg::S_UP_POS;
                end
            end

            cprf_pkg::S_UP_POS: begin
                if (r_k >= rp) begin
                    n_ri    = r_ri + 1'b1;
                    n_state = cprf_pkg::S_UP_RNG;
                end else begin
                    n_state = cprf_pkg::S_UP_CHK;
                end
            end

            cprf_pkg::S_UP_CHK: begin
                if (r_rdata != cprf_pkg::PG_FREE) begin
                    n_k     = PW'(r_k + 1'b1);
                    n_state = cprf_pkg::S_UP_POS;
                end else if ((addr52 & r_mask) != '0) begin
                    if (nk52 >= AW'(rp)) begin
                        n_ri    = r_ri + 1'b1;
                        n_state = cprf_pkg::S_UP_RNG;
                    end else begin
                        n_k     = PW'(nk52);
                        n_state = cprf_pkg::S_UP_POS;
                    end
                end else if (32'(rp) - 32'(r_k) < 32'(r_cnt)) begin
                    n_ri    = r_ri + 1'b1;
                    n_state = cprf_pkg::S_UP_RNG;
                end else if (r_cnt == 13'd1) begin
                    n_res   = 37'(addr52);
                    n_bot   = 37'(addr52 + AW'(r_cnt));
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end else begin
                    n_j     = 13'd1;
                    mem_ra  = IW'(32'(rf) + 32'(r_k) + 1);
                    n_state = cprf_pkg::S_UP_RUN;
                end
            end

            cprf_pkg::S_UP_RUN: begin
                if (r_rdata != cprf_pkg::PG_FREE) begin
                    n_k     = PW'(32'(r_k) + 32'(r_j) + 1);
                    n_state = cprf_pkg::S_UP_POS;
                end else if (r_j + 13'd1 == r_cnt) begin
                    n_res   = 37'(addr52);
                    n_bot   = 37'(addr52 + AW'(r_cnt));
                    n_stat  = cprf_pkg::STAT_OK;
                    n_state = cprf_pkg::S_EMIT;
                end else begin
                    n_j    = r_j + 1'b1;
                    mem_ra = IW'(32'(rf) + 32'(r_k) + 32'(r_j) + 1);
                end
            end

            cprf_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_stat;
                    n_out.result_frame    = r_res;
                    n_out.free_count      = 13'(r_free);
                    n_state               = cprf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = cprf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rng_we) begin
            r_rbase[rng_wi]  <= i_in_data.page_frame;
            r_rpages[rng_wi] <= PW'(i_in_data.run_len);
            r_rfirst[rng_wi] <= IW'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cprf_pkg::S_IDLE;
            r_rc        <= '0;
            r_used      <= '0;
            r_free      <= '0;
            r_top       <= '0;
            r_bot       <= '0;
            r_limit     <= cprf_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rc        <= n_rc;
            r_used      <= n_used;
            r_free      <= n_free;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat  <= n_stat;
        r_res   <= n_res;
        r_ri    <= n_ri;
        r_k     <= n_k;
        r_j     <= n_j;
        r_base0 <= n_base0;
        r_frame <= n_frame;
        r_cnt   <= n_cnt;
        r_mask  <= n_mask;
        r_st    <= n_st;
        r_out   <= n_out;
    end

    a_free_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cprf_pkg::S_LOAD) || (r_free <= r_used))
        else $error("free count exceeds mapped pages");

    a_used_le_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(PAGES) && 32'(r_rc) <= 32'(INTERVALS))
        else $error("map or range table overflow");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != cprf_pkg::S_IDLE)
        else $error("accepted request left no work");

endmodule

// ===== sim/tb_contiguous_page_run_finder_top.sv =====
// Self-checking testbench for contiguous_page_run_finder_top: directed and random
// requests, random idling on both sides, results checked by a page map scoreboard.
// Depends on cprf_pkg and the top level RTL.
`timescale 1ns / 1ps

class page_map_scoreboard;
    bit [1:0]        pg[4096];
    longint unsigned rng_base[8];
    int unsigned     rng_pages[8];
    int unsigned     rng_first[8];
    int unsigned     n_ranges;
    int unsigned     n_free;
    longint unsigned top_cur;
    longint unsigned bot_cur;
    longint unsigned low_limit = 256;
    cprf_pkg::t_out  expected_results[$];
    int              mismatches;
    int              n_checked;
    int              n_loads, n_sets, n_probes, n_probe_hits;

    function bit fit_down(int r, longint unsigned cnt, longint unsigned mask,
                          output longint unsigned res);
        longint unsigned b, top, al;
        longint k;
        int unsigned f;
        bit ok;
        b = rng_base[r];
        f = rng_first[r];
        k = longint'(rng_pages[r]) - 1;
        while (k >= 0) begin
            if (pg[f + k] != cprf_pkg::PG_FREE) begin
                k--;
                continue;
            end
            top = b + k + 1;
            if ((top & mask) != 0) begin
                al = top & ~mask;
                if (al <= b) return 0;
                k = longint'(al - b) - 1;
                continue;
            end
            if (longint'(k + 1) < longint'(cnt)) return 0;
            ok = 1;
            for (longint j = 0; j < cnt; j++) begin
                if (pg[f + k - j] != cprf_pkg::PG_FREE) begin
                    k = k - j - 1;
                    ok = 0;
                    break;
                end
            end
            if (ok) begin
                res = top;
                return 1;
            end
        end
        return 0;
    endfunction

    function bit fit_up(int r, longint unsigned cnt, longint unsigned mask,
                        output longint unsigned res);
        longint unsigned b, n, k, addr;
        int unsigned f;
        bit ok;
        b = rng_base[r];
        f = rng_first[r];
        n = rng_pages[r];
        k = 0;
        while (k < n) begin
            if (pg[f + k] != cprf_pkg::PG_FREE) begin
                k++;
                continue;
            end
            addr = b + k;
            if ((addr & mask) != 0) begin
                k = ((addr + mask) & ~mask) - b;
                continue;
            end
            if (n - k < cnt) return 0;
            ok = 1;
            for (longint unsigned j = 0; j < cnt; j++) begin
                if (pg[f + k + j] != cprf_pkg::PG_FREE) begin
                    k += j + 1;
                    ok = 0;
                    break;
                end
            end
            if (ok) begin
                res = addr;
                return 1;
            end
        end
        return 0;
    endfunction

    function cprf_pkg::t_status load_range(longint unsigned b, longint unsigned cnt);
        int unsigned used;
        bit lo;
        used = 0;
        if (cnt == 0 || n_ranges >= 8) return cprf_pkg::STAT_BAD;
        if (n_ranges > 0) used = rng_first[n_ranges - 1] + rng_pages[n_ranges - 1];
        if (cnt > 4096 - used) return cprf_pkg::STAT_BAD;
        rng_base[n_ranges] = b;
        rng_pages[n_ranges] = 32'(cnt);
        rng_first[n_ranges] = used;
        n_ranges++;
        for (longint unsigned p = 0; p < cnt; p++) begin
            lo = (b + p) < low_limit;
            pg[used + p] = lo ? cprf_pkg::PG_RESERVED : cprf_pkg::PG_FREE;
            if (!lo) n_free++;
        end
        top_cur = (b + cnt) & 37'h1FFFFFFFFF;
        bot_cur = rng_base[0] < low_limit ? low_limit : rng_base[0];
        return cprf_pkg::STAT_OK;
    endfunction

    function cprf_pkg::t_status set_run(longint unsigned s, longint unsigned cnt,
                                        bit [1:0] st);
        int unsigned r, idx;
        bit [1:0] old;
        if (cnt == 0) return cprf_pkg::STAT_BAD;
        for (r = 0; r < n_ranges; r++)
            if (s >= rng_base[r] && s < rng_base[r] + rng_pages[r]) break;
        if (r == n_ranges) return cprf_pkg::STAT_CROSS;
        if (s + cnt > rng_base[r] + rng_pages[r]) return cprf_pkg::STAT_CROSS;
        idx = rng_first[r] + 32'(s - rng_base[r]);
        for (int unsigned j = 0; j < cnt; j++) begin
            old = pg[idx + j];
            pg[idx + j] = st;
            if (old == cprf_pkg::PG_FREE && st != cprf_pkg::PG_FREE) n_free--;
            else if (old != cprf_pkg::PG_FREE && st == cprf_pkg::PG_FREE) n_free++;
        end
        return cprf_pkg::STAT_OK;
    endfunction

    function void note_request(cprf_pkg::t_in it);
        cprf_pkg::t_out e;
        longint unsigned cnt, mask, res;
        cprf_pkg::t_status st;
        cnt = 64'(it.run_len);
        mask = (it.align_exp < 12) ? 0 : ((64'd1 << (it.align_exp - 12)) - 1);
        res = 0;
        case (cprf_pkg::t_req'(it.req_type))
            cprf_pkg::REQ_LOAD: begin
                n_loads++;
                st = load_range(64'(it.page_frame), cnt);
            end
            cprf_pkg::REQ_SET: begin
                n_sets++;
                st = set_run(64'(it.page_frame), cnt, it.new_state);
            end
            cprf_pkg::REQ_DOWN: begin
                n_probes++;
                st = cprf_pkg::STAT_NOTFOUND;
                if (cnt == 0) st = cprf_pkg::STAT_BAD;
                else begin
                    for (int i = n_ranges; i > 0; i--) begin
                        if (rng_base[i - 1] >= top_cur) continue;
                        if (fit_down(i - 1, cnt, mask, res)) begin
                            top_cur = res & 37'h1FFFFFFFFF;
                            st = cprf_pkg::STAT_OK;
                            break;
                        end
                    end
                end
            end
            default: begin
                n_probes++;
                st = cprf_pkg::STAT_NOTFOUND;
                if (cnt == 0) st = cprf_pkg::STAT_BAD;
                else begin
                    for (int r = 0; r < n_ranges; r++) begin
                        if (rng_base[r] + rng_pages[r] <= bot_cur) continue;
                        if (fit_up(r, cnt, mask, res)) begin
                            bot_cur = (res + cnt) & 37'h1FFFFFFFFF;
                            st = cprf_pkg::STAT_OK;
                            break;
                        end
                    end
                end
            end
        endcase
        if (st != cprf_pkg::STAT_OK) res = 0;
        if (it.req_type[1] && st == cprf_pkg::STAT_OK) n_probe_hits++;
        e.status = st;
        e.result_frame = res[36:0];
        e.free_count = n_free[12:0];
        expected_results.push_back(e);
    endfunction

    function void check_result(cprf_pkg::t_out got);
        cprf_pkg::t_out e;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with none expected: %p", got);
            return;
        end
        e = expected_results.pop_front();
        n_checked++;
        if (got.status !== e.status || got.result_frame !== e.result_frame ||
            got.free_count !== e.free_count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d expected st=%0d frame=%h free=%0d,",
                         n_checked, e.status, e.result_frame, e.free_count,
                         " got st=%0d frame=%h free=%0d",
                         got.status, got.result_frame, got.free_count);
        end
    endfunction
endclass

module tb_contiguous_page_run_finder_top;

    localparam int IDLE_LIMIT = 60000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    cprf_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    cprf_pkg::t_out o_out_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [35:0]    i_cfg_data;

    page_map_scoreboard sb;
    bit quiet;
    bit hold_req;
    bit hold_done;
    int idle_cycles;

    contiguous_page_run_finder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [35:0] any_frame();
        return {4'($urandom_range(0, 15)), 32'($urandom())};
    endfunction

    function automatic cprf_pkg::t_in mk(cprf_pkg::t_req k, logic [35:0] f, int cnt,
                                         int al, int st);
        cprf_pkg::t_in it;
        it.req_type = k;
        it.page_frame = f;
        it.run_len = 13'(cnt);
        it.align_exp = 6'(al);
        it.new_state = 2'(st);
        return it;
    endfunction

    function automatic cprf_pkg::t_in random_request();
        int sel, r, off, cnt, al, p;
        logic [35:0] f;
        sel = $urandom_range(0, 99);
        p = $urandom_range(0, 99);
        al = p < 50 ? $urandom_range(0, 11) : (p < 90 ? $urandom_range(12, 18)
                                                         : $urandom_range(19, 47));
        if (sel < 3) begin
            f = ($urandom_range(0, 1)) ? any_frame() : 36'($urandom_range(0, 3000));
            return mk(cprf_pkg::REQ_LOAD, f, $urandom_range(0, 300), al,
                      $urandom_range(0, 3));
        end
        if (sel < 45) begin
            if (sb.n_ranges > 0 && $urandom_range(0, 9) < 8) begin
                r = $urandom_range(0, sb.n_ranges - 1);
                off = $urandom_range(0, sb.rng_pages[r] - 1);
                cnt = $urandom_range(1, (sb.rng_pages[r] - off) < 32 ?
                                        (sb.rng_pages[r] - off) : 32);
                if ($urandom_range(0, 19) == 0) cnt++;
                f = 36'(sb.rng_base[r] + off);
            end else begin
                f = any_frame();
                cnt = $urandom_range(0, 4096);
            end
            return mk(cprf_pkg::REQ_SET, f, cnt, al,
                      ($urandom_range(0, 99) < 45) ? cprf_pkg::PG_FREE
                                                   : $urandom_range(0, 3));
        end
        p = $urandom_range(0, 99);
        cnt = p < 85 ? $urandom_range(1, 16) : (p < 95 ? $urandom_range(0, 128)
                                                         : $urandom_range(0, 4096));
        return mk(sel < 73 ? cprf_pkg::REQ_DOWN : cprf_pkg::REQ_UP, any_frame(), cnt, al,
                  $urandom_range(0, 3));
    endfunction

    task automatic send_request(cprf_pkg::t_in it);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [35:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.low_limit = 64'(v);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_contiguous_page_run_finder_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_done = 1;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [35:0] limits[5];
        sb = new;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(36'd0);
        send_request(mk(cprf_pkg::REQ_DOWN, 0, 1, 0, 0));
        send_request(mk(cprf_pkg::REQ_UP, 0, 0, 0, 0));
        send_request(mk(cprf_pkg::REQ_LOAD, 0, 0, 0, 0));
        send_request(mk(cprf_pkg::REQ_LOAD, 0, 64, 0, 0));
        send_request(mk(cprf_pkg::REQ_UP, 0, 1, 0, 0));
        send_request(mk(cprf_pkg::REQ_DOWN, 0, 8, 14, 0));
        send_request(mk(cprf_pkg::REQ_SET, 10, 0, 0, 1));
        send_request(mk(cprf_pkg::REQ_SET, 36'd1000000, 1, 0, 1));
        send_request(mk(cprf_pkg::REQ_SET, 60, 10, 0, 2));
        send_request(mk(cprf_pkg::REQ_SET, 4, 8, 0, 3));
        send_request(mk(cprf_pkg::REQ_SET, 4, 4, 0, cprf_pkg::PG_FREE));
        send_request(mk(cprf_pkg::REQ_DOWN, 0, 4096, 0, 0));
        send_request(mk(cprf_pkg::REQ_UP, 0, 5, 47, 0));
        wait_drained();
        write_limit(36'hFFFFFFFFF);
        send_request(mk(cprf_pkg::REQ_LOAD, 36'hFFFFFFFC0, 64, 63, 3));
        send_request(mk(cprf_pkg::REQ_DOWN, 0, 2, 0, 0));
        send_request(mk(cprf_pkg::REQ_SET, 36'hFFFFFFFC0, 64, 0, cprf_pkg::PG_FREE));
        send_request(mk(cprf_pkg::REQ_DOWN, 36'hFFFFFFFFF, 64, 12, 0));
        send_request(mk(cprf_pkg::REQ_LOAD, 32, 40, 0, 0));
        send_request(mk(cprf_pkg::REQ_LOAD, 0, 4096, 0, 0));
        send_request(mk(cprf_pkg::REQ_SET, 40, 3, 0, 2));
        send_request(mk(cprf_pkg::REQ_UP, 0, 3, 13, 0));

        limits[0] = 36'd256;
        limits[1] = 36'd0;
        limits[2] = any_frame();
        limits[3] = 36'd300;
        limits[4] = 36'($urandom_range(0, 2000));
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_limit(limits[ph]);
            send_request(mk(cprf_pkg::REQ_LOAD,
                            (ph == 2) ? any_frame() : 36'($urandom_range(0, 2000)),
                            $urandom_range(16, 400), 0, 0));
            for (int i = 0; i < 165; i++) begin
                if (ph == 1 && i == 40) hold_req = 1;
                if (ph == 3 && i == 80) wait_drained();
                if (ph == 4 && i == 65) quiet = 1;
                send_request(random_request());
            end
        end
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d loads, %0d sets and %0d probes (%0d found a run);",
                 sb.n_loads, sb.n_sets, sb.n_probes, sb.n_probe_hits,
                 " %0d results checked.", sb.n_checked);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("tb_contiguous_page_run_finder_top passed");
        end else begin
            $display("Mismatches: %0d, results still expected: %0d",
                     sb.mismatches, sb.expected_results.size());
            $display("tb_contiguous_page_run_finder_top failed");
        end
        $finish;
    end
endmodule
